// ===== design/dlr_pkg.sv =====
`default_nettype none

package dlr_pkg;

    localparam int MAX_INPUTS_DEF  = 16;
    localparam int MAX_NEURONS_DEF = 16;
    localparam int RESULT_CAP      = 16;

    localparam int DATA_W  = 16;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 5;
    localparam int TDATA_W = 24;
    localparam int TUSER_W = 2;

    localparam logic [1:0] FUNC_WEIGHT = 2'd0;
    localparam logic [1:0] FUNC_BIAS   = 2'd1;
    localparam logic [1:0] FUNC_ELEM   = 2'd2;

    localparam logic [CFG_AW-1:0] REG_INPUTS  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_NEURONS = 2'd1;
    localparam logic [CFG_AW-1:0] REG_RELU    = 2'd2;

    localparam logic [CFG_DW-1:0] INPUTS_RST  = 5'd2;
    localparam logic [CFG_DW-1:0] NEURONS_RST = 5'd5;
    localparam logic              RELU_RST    = 1'b1;

    // tag that travels alongside a read through the memory and MAC stages
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } rd_tag_t;

endpackage

`default_nettype wire

// ===== design/dlr_store.sv =====
`default_nettype none

module dlr_store #(
    parameter int MAX_INPUTS  = dlr_pkg::MAX_INPUTS_DEF,
    parameter int MAX_NEURONS = dlr_pkg::MAX_NEURONS_DEF,
    localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
    localparam int NW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_weight,
    input  wire logic                          wr_bias,
    input  wire logic                          wr_elem,
    input  wire logic [NW-1:0]                 wr_neuron,
    input  wire logic [IW-1:0]                 wr_pos,
    input  wire logic [dlr_pkg::DATA_W-1:0]    wr_value,
    input  wire dlr_pkg::rd_tag_t              rd_tag,
    input  wire logic [NW-1:0]                 rd_k,
    input  wire logic [IW-1:0]                 rd_i,
    output dlr_pkg::rd_tag_t                   q_tag,
    output logic signed [dlr_pkg::DATA_W-1:0]  weight_q,
    output logic signed [dlr_pkg::DATA_W-1:0]  elem_q,
    output logic signed [dlr_pkg::DATA_W-1:0]  bias_q
);

    localparam int WDEPTH = MAX_INPUTS * MAX_NEURONS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    logic [dlr_pkg::DATA_W-1:0] wmem [WDEPTH];
    logic [dlr_pkg::DATA_W-1:0] bmem [MAX_NEURONS];
    logic [dlr_pkg::DATA_W-1:0] vmem [MAX_INPUTS];

    logic [WAW-1:0]   w_waddr;
    logic [WAW-1:0]   w_raddr;
    dlr_pkg::rd_tag_t q_tag_reg;

    assign w_waddr = WAW'(32'(wr_neuron) * MAX_INPUTS + 32'(wr_pos));
    assign w_raddr = WAW'(32'(rd_k) * MAX_INPUTS + 32'(rd_i));

    // writes happen only while the sequencer is idle; reads happen every cycle, tagged valid only while it runs
    always_ff @(posedge aclk) begin
        if (wr_weight) begin
            wmem[w_waddr] <= wr_value;
        end
        if (wr_bias) begin
            bmem[wr_neuron] <= wr_value;
        end
        if (wr_elem) begin
            vmem[wr_pos] <= wr_value;
        end
        weight_q <= wmem[w_raddr];
        elem_q   <= vmem[rd_i];
        bias_q   <= bmem[rd_k];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_tag_reg <= '0;
        end else begin
            q_tag_reg <= rd_tag;
        end
    end

    assign q_tag = q_tag_reg;

endmodule

`default_nettype wire

// ===== design/dlr_mac.sv =====
`default_nettype none

module dlr_mac #(
    parameter int MAX_INPUTS = dlr_pkg::MAX_INPUTS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire dlr_pkg::rd_tag_t                    in_tag,
    input  wire logic signed [dlr_pkg::DATA_W-1:0]   weight_q,
    input  wire logic signed [dlr_pkg::DATA_W-1:0]   elem_q,
    input  wire logic signed [dlr_pkg::DATA_W-1:0]   bias_q,
    input  wire logic                                relu_en,
    output logic                                     done,
    output logic [dlr_pkg::DATA_W-1:0]               result
);

    localparam int PW = 2 * dlr_pkg::DATA_W;
    localparam int AW = PW + 1 + ((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1);

    logic signed [PW-1:0]             prod_reg;
    logic signed [dlr_pkg::DATA_W-1:0] bias_s2_reg;
    dlr_pkg::rd_tag_t                 tag_s2_reg;
    logic signed [AW-1:0]             acc_reg;
    logic signed [AW-1:0]             acc_next;
    logic                             done_reg;

    logic signed [AW-1:0]             rounded;
    logic signed [AW-1:0]             floored;
    logic [dlr_pkg::DATA_W-1:0]       sat;

    always_ff @(posedge aclk) begin
        prod_reg    <= weight_q * elem_q;
        bias_s2_reg <= bias_q;
    end

    always_comb begin
        if (tag_s2_reg.first) begin
            acc_next = (AW'(bias_s2_reg) <<< 8) + AW'(prod_reg);
        end else begin
            acc_next = acc_reg + AW'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_s2_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_s2_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            tag_s2_reg <= in_tag;
            done_reg   <= tag_s2_reg.vld && tag_s2_reg.last;
        end
    end

    // round half up, floor shift, saturate, optional clamp at zero
    assign rounded = acc_reg + AW'(128);
    assign floored = rounded >>> 8;

    always_comb begin
        if (floored > AW'(32767)) begin
            sat = 16'h7FFF;
        end else if (floored < -AW'(32768)) begin
            sat = 16'h8000;
        end else begin
            sat = floored[dlr_pkg::DATA_W-1:0];
        end
    end

    assign result = (relu_en && sat[dlr_pkg::DATA_W-1]) ? '0 : sat;
    assign done   = done_reg;

endmodule

`default_nettype wire

// ===== design/dense_layer_relu.sv =====
// Weight, bias and non-final vector words are accepted back-to-back while idle.
// The final vector word starts the run: for each neuron in turn, the single shared
// multiply-accumulate walks one weight memory read per cycle over the N inputs used,
// then the result is pushed out; a stalled result holds the next neuron.
// Reset (aresetn low, synchronous) clears control and the config registers to 2, 5, 1;
// the weight, bias and vector memories are not cleared.
`default_nettype none

module dense_layer_relu #(
    parameter int MAX_INPUTS  = dlr_pkg::MAX_INPUTS_DEF,
    parameter int MAX_NEURONS = dlr_pkg::MAX_NEURONS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [3:0] neuron, [7:4] position, [23:8] value
    input  wire logic [dlr_pkg::TDATA_W-1:0]   s_tdata,
    // [1:0] func
    input  wire logic [dlr_pkg::TUSER_W-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] neuron_index, [19:4] activation, [23:20] zero
    output logic [dlr_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tlast,
    input  wire logic                          cfg_we,
    input  wire logic [dlr_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [dlr_pkg::CFG_DW-1:0]    cfg_wdata
);

    localparam int IW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int NW   = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int NCAP = (MAX_NEURONS < dlr_pkg::RESULT_CAP) ? MAX_NEURONS
                                                              : dlr_pkg::RESULT_CAP;
    localparam int ICW  = $clog2(MAX_INPUTS + 1);
    localparam int NCW  = $clog2(NCAP + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_PUSH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [NW-1:0] k_reg, k_next;

    logic [dlr_pkg::CFG_DW-1:0] inputs_reg;
    logic [dlr_pkg::CFG_DW-1:0] neurons_reg;
    logic                       relu_reg;

    logic [ICW-1:0] nin;
    logic [NCW-1:0] nn;

    logic [1:0]                 in_func;
    logic [3:0]                 in_neuron;
    logic [3:0]                 in_pos;
    logic [dlr_pkg::DATA_W-1:0] in_value;
    logic                       accept;
    logic                       nr_ok;
    logic                       pos_ok;
    logic                       start;
    logic                       last_i;
    logic                       last_k;
    logic                       out_free;
    logic                       load_out;

    dlr_pkg::rd_tag_t           rd_tag;
    dlr_pkg::rd_tag_t           q_tag;
    logic signed [dlr_pkg::DATA_W-1:0] weight_q;
    logic signed [dlr_pkg::DATA_W-1:0] elem_q;
    logic signed [dlr_pkg::DATA_W-1:0] bias_q;
    logic                       mac_done;
    logic [dlr_pkg::DATA_W-1:0] mac_result;

    logic                       m_tvalid_reg;
    logic                       m_tlast_reg;
    logic [3:0]                 idx_reg;
    logic [dlr_pkg::DATA_W-1:0] act_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inputs_reg  <= dlr_pkg::INPUTS_RST;
            neurons_reg <= dlr_pkg::NEURONS_RST;
            relu_reg    <= dlr_pkg::RELU_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                dlr_pkg::REG_INPUTS:  inputs_reg  <= cfg_wdata;
                dlr_pkg::REG_NEURONS: neurons_reg <= cfg_wdata;
                dlr_pkg::REG_RELU:    relu_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (inputs_reg == '0) begin
            nin = ICW'(1);
        end else if (32'(inputs_reg) > MAX_INPUTS) begin
            nin = ICW'(MAX_INPUTS);
        end else begin
            nin = ICW'(inputs_reg);
        end
        if (neurons_reg == '0) begin
            nn = NCW'(1);
        end else if (32'(neurons_reg) > NCAP) begin
            nn = NCW'(NCAP);
        end else begin
            nn = NCW'(neurons_reg);
        end
    end

    assign in_func   = s_tuser[1:0];
    assign in_neuron = s_tdata[3:0];
    assign in_pos    = s_tdata[7:4];
    assign in_value  = s_tdata[23:8];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign nr_ok    = 32'(in_neuron) < MAX_NEURONS;
    assign pos_ok   = 32'(in_pos) < MAX_INPUTS;
    assign start    = accept && (in_func == dlr_pkg::FUNC_ELEM) && pos_ok
                      && (32'(in_pos) == 32'(nin) - 32'd1);

    assign last_i   = 32'(i_reg) == 32'(nin) - 32'd1;
    assign last_k   = 32'(k_reg) == 32'(nn) - 32'd1;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        load_out     = 1'b0;
        rd_tag       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                rd_tag.vld   = 1'b1;
                rd_tag.first = (i_reg == '0);
                rd_tag.last  = last_i;
                if (last_i) begin
                    i_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    i_next = IW'(i_reg + 1'b1);
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (last_k) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = NW'(k_reg + 1'b1);
                        state_next = ST_RUN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
        end
    end

    dlr_store #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_NEURONS (MAX_NEURONS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_weight (accept && (in_func == dlr_pkg::FUNC_WEIGHT) && nr_ok && pos_ok),
        .wr_bias   (accept && (in_func == dlr_pkg::FUNC_BIAS) && nr_ok),
        .wr_elem   (accept && (in_func == dlr_pkg::FUNC_ELEM) && pos_ok),
        .wr_neuron (NW'(in_neuron)),
        .wr_pos    (IW'(in_pos)),
        .wr_value  (in_value),
        .rd_tag    (rd_tag),
        .rd_k      (k_reg),
        .rd_i      (i_reg),
        .q_tag     (q_tag),
        .weight_q  (weight_q),
        .elem_q    (elem_q),
        .bias_q    (bias_q)
    );

    dlr_mac #(
        .MAX_INPUTS (MAX_INPUTS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (q_tag),
        .weight_q (weight_q),
        .elem_q   (elem_q),
        .bias_q   (bias_q),
        .relu_en  (relu_reg),
        .done     (mac_done),
        .result   (mac_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            idx_reg     <= 4'(k_reg);
            act_reg     <= mac_result;
            m_tlast_reg <= last_k;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {4'b0000, act_reg, idx_reg};

endmodule

`default_nettype wire

// ===== design/dlr_checker.sv =====
`default_nettype none

module dlr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dlr_pkg::TDATA_W-1:0]   m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          cfg_we,
    input wire logic [dlr_pkg::CFG_AW-1:0]    cfg_addr,
    input wire logic [dlr_pkg::CFG_DW-1:0]    cfg_wdata
);

    logic [3:0] exp_idx_reg;
    logic       relu_reg;
    logic       out_acc;

    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
            relu_reg    <= dlr_pkg::RELU_RST;
        end else begin
            if (out_acc) begin
                exp_idx_reg <= m_tlast ? 4'd0 : 4'(m_tdata[3:0] + 1'b1);
            end
            if (cfg_we && (cfg_addr == dlr_pkg::REG_RELU)) begin
                relu_reg <= cfg_wdata[0];
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_idx_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> m_tdata[3:0] == exp_idx_reg)
        else $error("neuron index out of sequence");

    a_busy_mid_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while a vector is still being computed");

    a_relu_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && relu_reg |-> !m_tdata[19])
        else $error("negative activation with relu enabled");

endmodule

bind dense_layer_relu dlr_checker u_dlr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
);

`default_nettype wire
